// ----- src/ccd_pkg.sv -----
// Shared types and constants for the CR LF command deframer.
`timescale 1ns / 1ps

package ccd_pkg;

   localparam int MAX_COMMAND_BYTES = 32;
   localparam int ADDR_W = (MAX_COMMAND_BYTES > 1) ? $clog2(MAX_COMMAND_BYTES) : 1;
   localparam int FILL_W = $clog2(MAX_COMMAND_BYTES + 1);
   localparam int BYTE_W = 8;
   localparam int STAT_W = 2;
   localparam int LEN_W = 6;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic [BYTE_W-1:0] CH_CR = 8'h0D;
   localparam logic [BYTE_W-1:0] CH_LF = 8'h0A;

   typedef enum logic [STAT_W-1:0] {
      STAT_DATA     = 2'd0,
      STAT_EMPTY    = 2'd1,
      STAT_OVERLONG = 2'd2
   } status_type;

   typedef enum logic [1:0] {
      OP_OPEN  = 2'd0,
      OP_DATA  = 2'd1,
      OP_CLOSE = 2'd2
   } op_type;

   typedef struct packed {
      op_type              op;
      logic [BYTE_W-1:0]   data;
   } cmd_type;

endpackage

// ----- src/ccd_front.sv -----
// Front end: byte acceptance and CR LF framing state machine.
`timescale 1ns / 1ps

module ccd_front (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ccd_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                       q_full,
   output logic                       push,
   output ccd_pkg::cmd_type           push_cmd
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_OPEN_CR,
      PH_BODY,
      PH_CLOSE_CR
   } phase_type;

   phase_type phase_ff;
   phase_type phase_in;
   logic      accept;
   logic      is_cr;
   logic      is_lf;

   assign req_ready = !q_full;
   assign accept    = req_valid && req_ready;
   assign is_cr     = (req_rx_byte == ccd_pkg::CH_CR);
   assign is_lf     = (req_rx_byte == ccd_pkg::CH_LF);

   always_comb begin
      phase_in      = phase_ff;
      push          = 1'b0;
      push_cmd.op   = ccd_pkg::OP_DATA;
      push_cmd.data = req_rx_byte;
      if (accept) begin
         unique case (phase_ff)
            PH_HUNT: begin
               if (is_cr) phase_in = PH_OPEN_CR;
            end
            PH_OPEN_CR: begin
               if (is_lf) begin
                  phase_in    = PH_BODY;
                  push        = 1'b1;
                  push_cmd.op = ccd_pkg::OP_OPEN;
               end else if (is_cr) begin
                  phase_in = PH_OPEN_CR;  // rescanned as a fresh opening CR
               end else begin
                  phase_in = PH_HUNT;
               end
            end
            PH_BODY: begin
               if (is_cr) begin
                  phase_in = PH_CLOSE_CR;
               end else begin
                  push        = 1'b1;
                  push_cmd.op = ccd_pkg::OP_DATA;
               end
            end
            PH_CLOSE_CR: begin
               phase_in = PH_HUNT;
               if (is_lf) begin
                  push        = 1'b1;
                  push_cmd.op = ccd_pkg::OP_CLOSE;
               end
            end
            default: phase_in = PH_HUNT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_HUNT;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

// ----- src/ccd_queue.sv -----
// Short command queue between the front end and the back end.
`timescale 1ns / 1ps

module ccd_queue (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  ccd_pkg::cmd_type push_cmd,
   output logic             full,
   input  logic             pop,
   output logic             head_valid,
   output ccd_pkg::cmd_type head_cmd
);

   ccd_pkg::cmd_type                  q_ff [ccd_pkg::QUEUE_DEPTH];
   logic [ccd_pkg::QPTR_W-1:0]        wr_ptr_ff;
   logic [ccd_pkg::QPTR_W-1:0]        rd_ptr_ff;
   logic [ccd_pkg::QCNT_W-1:0]        count_ff;

   assign full       = (count_ff == ccd_pkg::QCNT_W'(ccd_pkg::QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_cmd   = q_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) q_ff[wr_ptr_ff] <= push_cmd;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) wr_ptr_ff <= wr_ptr_ff + 1'b1;
         if (pop)  rd_ptr_ff <= rd_ptr_ff + 1'b1;
         unique case ({push, pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ----- src/ccd_back.sv -----
// Back end: command store, fill tracking and result emission.
`timescale 1ns / 1ps

module ccd_back (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       head_valid,
   input  ccd_pkg::cmd_type           head_cmd,
   output logic                       pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ccd_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic [ccd_pkg::STAT_W-1:0] rsp_frame_status,
   output logic [ccd_pkg::LEN_W-1:0]  rsp_command_length,
   output logic                       rsp_last_of_frame
);

   typedef enum logic [1:0] {
      B_IDLE,
      B_FETCH,
      B_SEND
   } back_state_type;

   back_state_type                 state_ff;
   logic [ccd_pkg::BYTE_W-1:0]     store_mem [ccd_pkg::MAX_COMMAND_BYTES];
   logic [ccd_pkg::BYTE_W-1:0]     rd_data_ff;
   logic [ccd_pkg::FILL_W-1:0]     fill_ff;
   logic [ccd_pkg::FILL_W-1:0]     idx_ff;
   logic                           ovf_ff;

   logic                           rsp_valid_ff;
   logic [ccd_pkg::BYTE_W-1:0]     out_byte_ff;
   ccd_pkg::status_type            status_ff;
   logic [ccd_pkg::LEN_W-1:0]      length_ff;
   logic                           last_ff;

   logic                           out_free;
   logic                           room;
   logic                           close_short;
   logic                           mem_we;
   logic                           idx_last;

   assign out_free    = !rsp_valid_ff || rsp_ready;
   assign room        = (fill_ff < ccd_pkg::FILL_W'(ccd_pkg::MAX_COMMAND_BYTES));
   assign close_short = (head_cmd.op == ccd_pkg::OP_CLOSE) && (ovf_ff || fill_ff == '0);
   assign pop         = (state_ff == B_IDLE) && head_valid && (!close_short || out_free);
   assign mem_we      = (state_ff == B_IDLE) && head_valid
                        && (head_cmd.op == ccd_pkg::OP_DATA) && room;
   assign idx_last    = ((idx_ff + 1'b1) == fill_ff);

   // store: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) store_mem[fill_ff[ccd_pkg::ADDR_W-1:0]] <= head_cmd.data;
      rd_data_ff <= store_mem[idx_ff[ccd_pkg::ADDR_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         fill_ff      <= '0;
         ovf_ff       <= 1'b0;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            B_IDLE: begin
               if (head_valid) begin
                  unique case (head_cmd.op)
                     ccd_pkg::OP_OPEN: begin
                        fill_ff <= '0;
                        ovf_ff  <= 1'b0;
                     end
                     ccd_pkg::OP_DATA: begin
                        if (room) fill_ff <= fill_ff + 1'b1;
                        else      ovf_ff  <= 1'b1;
                     end
                     ccd_pkg::OP_CLOSE: begin
                        if (close_short) begin
                           if (out_free) begin
                              rsp_valid_ff <= 1'b1;
                              out_byte_ff  <= '0;
                              status_ff    <= ovf_ff ? ccd_pkg::STAT_OVERLONG
                                                     : ccd_pkg::STAT_EMPTY;
                              length_ff    <= '0;
                              last_ff      <= 1'b1;
                           end
                        end else begin
                           idx_ff   <= '0;
                           state_ff <= B_FETCH;
                        end
                     end
                     default: state_ff <= B_IDLE;
                  endcase
               end
            end
            B_FETCH: begin
               state_ff <= B_SEND;
            end
            B_SEND: begin
               if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  out_byte_ff  <= rd_data_ff;
                  status_ff    <= ccd_pkg::STAT_DATA;
                  length_ff    <= ccd_pkg::LEN_W'(fill_ff);
                  last_ff      <= idx_last;
                  idx_ff       <= idx_ff + 1'b1;
                  state_ff     <= idx_last ? B_IDLE : B_FETCH;
               end
            end
            default: state_ff <= B_IDLE;
         endcase
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_out_byte       = out_byte_ff;
   assign rsp_frame_status   = status_ff;
   assign rsp_command_length = length_ff;
   assign rsp_last_of_frame  = last_ff;

endmodule

// ----- src/crlf_command_deframer.sv -----
// Top level of the CR LF command deframer: front end, command queue, back end.
`timescale 1ns / 1ps
// Throughput: one rx beat per cycle while the 4-entry command queue has room.
// A closing CR LF yields n data beats, each read from the store and then
// moved into the output register, as the command store has a single read port.
// An empty/overlong result skips the store read; a data frame reads it first.
// Reset (synchronous, active high) returns to hunting and empties the queue;
// the command store is not cleared, since only written entries are read.

module crlf_command_deframer (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [ccd_pkg::BYTE_W-1:0] req_rx_byte,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [ccd_pkg::BYTE_W-1:0] rsp_out_byte,
   output logic [ccd_pkg::STAT_W-1:0] rsp_frame_status,
   output logic [ccd_pkg::LEN_W-1:0]  rsp_command_length,
   output logic                       rsp_last_of_frame
);

   // front to queue
   logic             push;
   ccd_pkg::cmd_type push_cmd;
   logic             q_full;

   // queue to back
   logic             pop;
   logic             head_valid;
   ccd_pkg::cmd_type head_cmd;

   // Front: tracks the CR LF phase and turns rx beats into open / data /
   // close commands (nothing for CR beats, broken framing, or while hunting).
   ccd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_rx_byte (req_rx_byte),
      .q_full      (q_full),
      .push        (push),
      .push_cmd    (push_cmd)
   );

   // Queue decouples byte intake from the result burst.
   ccd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_cmd   (push_cmd),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_cmd   (head_cmd)
   );

   // Back: owns the store, fill count and overflow flag; plays out frames.
   ccd_back u_back (
      .clock              (clock),
      .reset              (reset),
      .head_valid         (head_valid),
      .head_cmd           (head_cmd),
      .pop                (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_command_length (rsp_command_length),
      .rsp_last_of_frame  (rsp_last_of_frame)
   );

endmodule

// ----- src/ccd_checker.sv -----
// Port-level checks for the CR LF command deframer, bound to the top level.
`timescale 1ns / 1ps

module ccd_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       rsp_valid,
   input logic                       rsp_ready,
   input logic [ccd_pkg::BYTE_W-1:0] rsp_out_byte,
   input logic [ccd_pkg::STAT_W-1:0] rsp_frame_status,
   input logic [ccd_pkg::LEN_W-1:0]  rsp_command_length,
   input logic                       rsp_last_of_frame
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("rsp_valid dropped before the beat was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_out_byte) && $stable(rsp_frame_status)
         && $stable(rsp_command_length) && $stable(rsp_last_of_frame))
      else $error("rsp payload changed while stalled");

   a_status_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_frame_status != ccd_pkg::STAT_DATA |->
         rsp_out_byte == '0 && rsp_command_length == '0 && rsp_last_of_frame)
      else $error("empty/overlong beat must be a lone zero beat");

   a_reset_idle: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("rsp_valid high right after reset");

endmodule

bind crlf_command_deframer ccd_checker u_ccd_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_out_byte       (rsp_out_byte),
   .rsp_frame_status   (rsp_frame_status),
   .rsp_command_length (rsp_command_length),
   .rsp_last_of_frame  (rsp_last_of_frame)
);

// ----- dv/crlf_command_deframer_checker.sv -----
// Checker for the CR LF command deframer: predicts result beats and compares them.
`timescale 1ns / 1ps

module crlf_command_deframer_checker (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [ccd_pkg::BYTE_W-1:0] req_rx_byte,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic [ccd_pkg::BYTE_W-1:0] rsp_out_byte,
   input  logic [ccd_pkg::STAT_W-1:0] rsp_frame_status,
   input  logic [ccd_pkg::LEN_W-1:0]  rsp_command_length,
   input  logic                       rsp_last_of_frame,
   output int                         mismatch_count,
   output int                         outstanding
);

   typedef enum logic [1:0] {
      PH_HUNT,
      PH_OPEN_CR,
      PH_BODY,
      PH_CLOSE_CR
   } phase_type;

   typedef struct packed {
      logic [ccd_pkg::BYTE_W-1:0] data;
      ccd_pkg::status_type        status;
      logic [ccd_pkg::LEN_W-1:0]  cmd_len;
      logic                       last;
   } cmd_beat_type;

   phase_type                  phase = PH_HUNT;
   logic [ccd_pkg::BYTE_W-1:0] cmd_bytes [ccd_pkg::MAX_COMMAND_BYTES];
   int unsigned                fill = 0;
   logic                       overlong = 1'b0;
   cmd_beat_type               due_beats [$];
   int                         mismatches = 0;

   task automatic push_beat(input logic [ccd_pkg::BYTE_W-1:0] data,
                            input ccd_pkg::status_type status,
                            input logic [ccd_pkg::LEN_W-1:0] cmd_len,
                            input logic last);
      cmd_beat_type beat;
      beat.data = data;
      beat.status = status;
      beat.cmd_len = cmd_len;
      beat.last = last;
      due_beats.push_back(beat);
   endtask

   // one rx byte through the framing state; a completed frame queues its beats
   task automatic deframe_byte(input logic [ccd_pkg::BYTE_W-1:0] b);
      case (phase)
         PH_HUNT: begin
            if (b == ccd_pkg::CH_CR) phase = PH_OPEN_CR;
         end
         PH_OPEN_CR: begin
            if (b == ccd_pkg::CH_LF) begin
               phase = PH_BODY;
               fill = 0;
               overlong = 1'b0;
            end else begin
               // bad byte is looked at again as a hunting byte
               phase = (b == ccd_pkg::CH_CR) ? PH_OPEN_CR : PH_HUNT;
            end
         end
         PH_BODY: begin
            if (b == ccd_pkg::CH_CR) begin
               phase = PH_CLOSE_CR;
            end else if (fill < ccd_pkg::MAX_COMMAND_BYTES) begin
               cmd_bytes[fill] = b;
               fill++;
            end else begin
               overlong = 1'b1;
            end
         end
         default: begin
            phase = PH_HUNT;
            if (b == ccd_pkg::CH_LF) begin
               if (overlong) begin
                  push_beat('0, ccd_pkg::STAT_OVERLONG, '0, 1'b1);
               end else if (fill == 0) begin
                  push_beat('0, ccd_pkg::STAT_EMPTY, '0, 1'b1);
               end else begin
                  for (int i = 0; i < fill; i++)
                     push_beat(cmd_bytes[i], ccd_pkg::STAT_DATA,
                               ccd_pkg::LEN_W'(fill), (i + 1 == fill));
               end
            end
         end
      endcase
   endtask

   task automatic check_beat();
      cmd_beat_type want;
      if (due_beats.size() == 0) begin
         mismatches++;
         if (mismatches <= 10)
            $display("%0t: unexpected beat: byte %02h status %0d len %0d last %0b",
                     $time, rsp_out_byte, rsp_frame_status, rsp_command_length,
                     rsp_last_of_frame);
      end else begin
         want = due_beats.pop_front();
         if (rsp_out_byte !== want.data || rsp_frame_status !== want.status ||
             rsp_command_length !== want.cmd_len || rsp_last_of_frame !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("%0t: beat mismatch: expected byte %02h status %0d len %0d last %0b",
                        $time, want.data, want.status, want.cmd_len, want.last);
               $display("%0t:                got      byte %02h status %0d len %0d last %0b",
                        $time, rsp_out_byte, rsp_frame_status, rsp_command_length,
                        rsp_last_of_frame);
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         phase = PH_HUNT;
         fill = 0;
         overlong = 1'b0;
         due_beats.delete();
      end else begin
         // a result never leaves in the cycle of its closing LF, so check first
         if (rsp_valid && rsp_ready) check_beat();
         if (req_valid && req_ready) deframe_byte(req_rx_byte);
      end
      mismatch_count <= mismatches;
      outstanding <= due_beats.size();
   end

endmodule

// ----- dv/crlf_command_deframer_tb.sv -----
// Testbench top for the CR LF command deframer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module crlf_command_deframer_tb;

   // About 250 rx beats in all: the directed ones, then random chunks.
   localparam int unsigned TOTAL_BYTES = 250;
   // Keep plenty of margin over the slowest run.
   localparam int unsigned CYCLE_LIMIT = 300000;
   // Quiet time after the last expected beat.
   localparam int unsigned DRAIN_CYCLES = 24;

   // Directed opening: empty frame, extreme data bytes, a second CR that
   // reopens, an abandoned frame (CR then non-LF), and a bad byte after CR.
   localparam logic [ccd_pkg::BYTE_W-1:0] DIRECTED [25] = '{
      ccd_pkg::CH_CR, ccd_pkg::CH_LF, ccd_pkg::CH_CR, ccd_pkg::CH_LF,
      ccd_pkg::CH_CR, ccd_pkg::CH_LF, 8'h00, 8'hFF, ccd_pkg::CH_CR, ccd_pkg::CH_LF,
      ccd_pkg::CH_CR, ccd_pkg::CH_CR, ccd_pkg::CH_LF, 8'h41, ccd_pkg::CH_CR,
      ccd_pkg::CH_LF,
      ccd_pkg::CH_CR, ccd_pkg::CH_LF, 8'h42, ccd_pkg::CH_CR, 8'h43,
      ccd_pkg::CH_LF, ccd_pkg::CH_CR, 8'h58, ccd_pkg::CH_LF
   };

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [ccd_pkg::BYTE_W-1:0] req_rx_byte = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic [ccd_pkg::BYTE_W-1:0] rsp_out_byte;
   logic [ccd_pkg::STAT_W-1:0] rsp_frame_status;
   logic [ccd_pkg::LEN_W-1:0]  rsp_command_length;
   logic                       rsp_last_of_frame;

   int                         mismatch_count;
   int                         outstanding;
   logic                       idle_on = 1'b1;
   int unsigned                cycles = 0;
   int unsigned                bytes_sent = 0;

   crlf_command_deframer dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_out_byte       (rsp_out_byte),
      .rsp_frame_status   (rsp_frame_status),
      .rsp_command_length (rsp_command_length),
      .rsp_last_of_frame  (rsp_last_of_frame)
   );

   crlf_command_deframer_checker u_checker (.*);

   initial begin
      forever #5 clock = ~clock;
   end

   // Hard stop; a hang or a lost beat ends up here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // Sink side: back-pressure about 6 percent of the time unless idling is off.
   always @(posedge clock) begin
      rsp_ready <= !(idle_on && $urandom_range(0, 99) < 6);
   end

   // Present one rx beat and hold it until accepted. An optional random gap
   // comes first; valid drops only then, so back-to-back beats keep it high.
   task automatic send_byte(input logic [ccd_pkg::BYTE_W-1:0] b);
      int unsigned gap;
      gap = 0;
      while (idle_on && $urandom_range(0, 99) < 6) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_rx_byte <= b;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      bytes_sent++;
   endtask

   // Any byte but CR, so a body stays inside its frame. LF is allowed and stored.
   function automatic logic [ccd_pkg::BYTE_W-1:0] body_char();
      logic [ccd_pkg::BYTE_W-1:0] b;
      do b = ccd_pkg::BYTE_W'($urandom_range(0, 255)); while (b == ccd_pkg::CH_CR);
      return b;
   endfunction

   // Anything but LF, biased toward CR to hit the reopen path.
   function automatic logic [ccd_pkg::BYTE_W-1:0] non_lf_char();
      logic [ccd_pkg::BYTE_W-1:0] b;
      if ($urandom_range(0, 3) == 0) return ccd_pkg::CH_CR;
      do b = ccd_pkg::BYTE_W'($urandom_range(0, 255)); while (b == ccd_pkg::CH_LF);
      return b;
   endfunction

   // Mostly short commands; now and then the store edge and just past it.
   function automatic int unsigned body_len();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 10) return 0;
      if (pick < 70) return $urandom_range(1, 6);
      if (pick < 84) return $urandom_range(7, 20);
      if (pick < 92)
         return $urandom_range(ccd_pkg::MAX_COMMAND_BYTES - 1, ccd_pkg::MAX_COMMAND_BYTES);
      return $urandom_range(ccd_pkg::MAX_COMMAND_BYTES + 1, ccd_pkg::MAX_COMMAND_BYTES + 4);
   endfunction

   task automatic send_frame(input int unsigned n);
      send_byte(ccd_pkg::CH_CR);
      send_byte(ccd_pkg::CH_LF);
      repeat (n) send_byte(body_char());
      send_byte(ccd_pkg::CH_CR);
      send_byte(ccd_pkg::CH_LF);
   endtask

   // One random chunk: a well-formed frame most of the time, otherwise line
   // noise rich in CR/LF, an abandoned frame, or a broken opening.
   task automatic random_chunk(input int unsigned seq);
      int unsigned pick;
      int unsigned n;
      pick = $urandom_range(0, 99);
      if (seq == 0) begin
         send_frame(ccd_pkg::MAX_COMMAND_BYTES);
      end else if (seq == 1) begin
         send_frame(ccd_pkg::MAX_COMMAND_BYTES + 1);
      end else if (pick < 75) begin
         send_frame(body_len());
      end else if (pick < 85) begin
         n = $urandom_range(1, 6);
         repeat (n) begin
            case ($urandom_range(0, 2))
               0: send_byte(ccd_pkg::CH_CR);
               1: send_byte(ccd_pkg::CH_LF);
               default: send_byte(ccd_pkg::BYTE_W'($urandom_range(0, 255)));
            endcase
         end
      end else if (pick < 93) begin
         send_byte(ccd_pkg::CH_CR);
         send_byte(ccd_pkg::CH_LF);
         n = $urandom_range(0, 5);
         repeat (n) send_byte(body_char());
         send_byte(ccd_pkg::CH_CR);
         send_byte(non_lf_char());
      end else begin
         send_byte(ccd_pkg::CH_CR);
         send_byte(non_lf_char());
      end
   endtask

   initial begin
      int unsigned seq;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED[i]) send_byte(DIRECTED[i]);

      // Chunks 6..14 run with no idling on either side.
      seq = 0;
      while (bytes_sent < TOTAL_BYTES) begin
         idle_on <= (seq < 6 || seq > 14);
         random_chunk(seq);
         seq++;
      end
      req_valid <= 1'b0;
      idle_on <= 1'b1;

      // Let the checker see the last beat, then drain.
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
